FILE: rtl/seven_segment_digit_scan_unit_defines.svh
// Assertion macros used by the checker file of the digit scan unit.
`ifndef SEVEN_SEGMENT_DIGIT_SCAN_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_DIGIT_SCAN_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SDS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sds_pkg.sv
// Shared types, constants and digit arithmetic of the seven-segment digit scan unit.
package sds_pkg;

   localparam int VALUE_W = 14;
   localparam int POS_W = 2;
   localparam int DIGITS = 4;
   localparam int SEG_W = 7;
   localparam int DIGIT_W = 4;
   localparam int Q10_W = 11;
   localparam int Q100_W = 8;
   localparam int Q1000_W = 5;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd0;
   localparam logic [POS_W-1:0] POS_TENS = 2'd1;
   localparam logic [POS_W-1:0] POS_UNITS = 2'd2;
   localparam logic [POS_W-1:0] POS_TENTHS = 2'd3;

   localparam logic [VALUE_W-1:0] HUNDREDS_BLANK_LIMIT = 14'd1000;
   localparam logic [VALUE_W-1:0] TENS_BLANK_LIMIT = 14'd100;

   localparam logic [SEG_W-1:0] SEG_BLANK_N = 7'h7F;

   // Reciprocal constants, exact for every 14-bit operand.
   localparam logic [15:0] DIV10_MUL = 16'd52429;
   localparam int DIV10_SHIFT = 19;
   localparam logic [15:0] DIV100_MUL = 16'd41944;
   localparam int DIV100_SHIFT = 22;
   localparam logic [13:0] DIV1000_MUL = 14'd8389;
   localparam int DIV1000_SHIFT = 23;

   typedef struct packed {
      logic [VALUE_W-1:0] value_tenths;
      logic [Q10_W-1:0] quot_10;
      logic [Q100_W-1:0] quot_100;
      logic [Q1000_W-1:0] quot_1000;
      logic decimal_all;
   } quot_type;

   typedef struct packed {
      logic point_n;
      logic [SEG_W-1:0] segments_n;
      logic [DIGITS-1:0] digit_enable;
      logic [POS_W-1:0] digit_index;
   } rsp_fields_type;

   function automatic logic [Q10_W-1:0] div10_f(input logic [VALUE_W-1:0] x);
      logic [29:0] prod;
      prod = 30'(x) * 30'(DIV10_MUL);
      return prod[DIV10_SHIFT +: Q10_W];
   endfunction

   function automatic logic [Q100_W-1:0] div100_f(input logic [VALUE_W-1:0] x);
      logic [29:0] prod;
      prod = 30'(x) * 30'(DIV100_MUL);
      return prod[DIV100_SHIFT +: Q100_W];
   endfunction

   function automatic logic [Q1000_W-1:0] div1000_f(input logic [VALUE_W-1:0] x);
      logic [27:0] prod;
      prod = 28'(x) * 28'(DIV1000_MUL);
      return prod[DIV1000_SHIFT +: Q1000_W];
   endfunction

   function automatic logic [DIGIT_W-1:0] mod10_f(input logic [VALUE_W-1:0] x);
      logic [VALUE_W-1:0] tens;
      logic [VALUE_W-1:0] rem;
      tens = {3'b000, div10_f(x)};
      rem = x - ((tens << 3) + (tens << 1));
      return rem[DIGIT_W-1:0];
   endfunction

   function automatic logic [SEG_W-1:0] seg_on_f(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] seg;
      case (d)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h6F;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

FILE: rtl/sds_quot_stage.sv
// Input register stage that holds the value and its quotients by 10, 100 and 1000.
module sds_quot_stage
   import sds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic req_tuser,
   output logic quot_valid,
   input  logic quot_ready,
   output quot_type quot_data
);

   logic valid_ff;
   logic valid_in;
   quot_type data_ff;
   quot_type data_in;
   logic [VALUE_W-1:0] value;

   assign value = req_tdata[VALUE_W-1:0];
   assign req_tready = !valid_ff || quot_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
      data_in.value_tenths = value;
      data_in.quot_10 = div10_f(value);
      data_in.quot_100 = div100_f(value);
      data_in.quot_1000 = div1000_f(value);
      data_in.decimal_all = req_tuser;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= data_in;
      end
   end

   assign quot_valid = valid_ff;
   assign quot_data = data_ff;

endmodule

FILE: rtl/sds_digit_stage.sv
// Digit pointer, digit selection, segment decode and result register.
module sds_digit_stage
   import sds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic quot_valid,
   output logic quot_ready,
   input  quot_type quot_data,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [POS_W-1:0] pointer_ff;
   logic [POS_W-1:0] pointer_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   rsp_fields_type rsp_data_ff;
   rsp_fields_type rsp_data_in;
   logic take;
   logic [POS_W-1:0] pos;
   logic [VALUE_W-1:0] quot_sel;
   logic [DIGIT_W-1:0] digit;
   logic blank;

   assign quot_ready = !rsp_valid_ff || rsp_tready;
   assign take = quot_valid && quot_ready;
   assign pos = pointer_ff + 2'd1;

   always_comb begin
      case (pos)
         POS_HUNDREDS: quot_sel = VALUE_W'(quot_data.quot_1000);
         POS_TENS: quot_sel = VALUE_W'(quot_data.quot_100);
         POS_UNITS: quot_sel = VALUE_W'(quot_data.quot_10);
         POS_TENTHS: quot_sel = quot_data.value_tenths;
         default: quot_sel = quot_data.value_tenths;
      endcase
   end

   assign digit = mod10_f(quot_sel);
   assign blank = ((pos == POS_HUNDREDS) && (quot_data.value_tenths < HUNDREDS_BLANK_LIMIT))
      || ((pos == POS_TENS) && (quot_data.value_tenths < TENS_BLANK_LIMIT));

   always_comb begin
      pointer_in = take ? pos : pointer_ff;
      rsp_valid_in = rsp_valid_ff;
      if (quot_ready) begin
         rsp_valid_in = quot_valid;
      end
      rsp_data_in.digit_index = pos;
      rsp_data_in.digit_enable = DIGITS'(1) << pos;
      rsp_data_in.segments_n = blank ? SEG_BLANK_N : ~seg_on_f(digit);
      rsp_data_in.point_n = !((pos == POS_UNITS) || quot_data.decimal_all);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pointer_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pointer_ff <= pointer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {(RSP_DATA_W - $bits(rsp_fields_type))'(0), rsp_data_ff};

endmodule

FILE: rtl/seven_segment_digit_scan_unit.sv
// Top level of the seven-segment digit scan unit.
// A request passes the quotient register and then the result register of the digit stage;
// either register holds its transaction while the stage behind it is not ready.
// Throughput: one transaction per cycle while rsp_tready stays high, set by the two register
// stages around the quotient multipliers and the digit decode.
// Reset clears both valid flags and the digit pointer, so the first result drives digit 1.
module seven_segment_digit_scan_unit
   import sds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value_tenths[13:0], zeros [15:14]
   input  logic req_tuser,                   // decimal_all
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // digit_index[1:0], digit_enable[5:2],
                                             // segments_n[12:6], point_n[13], zeros
);

   logic quot_valid;
   logic quot_ready;
   quot_type quot_data;

   sds_quot_stage u_quot (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .quot_valid(quot_valid),
      .quot_ready(quot_ready),
      .quot_data(quot_data)
   );

   sds_digit_stage u_digit (
      .clock(clock),
      .reset(reset),
      .quot_valid(quot_valid),
      .quot_ready(quot_ready),
      .quot_data(quot_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

endmodule

FILE: rtl/sds_checker.sv
// Port-level checker of the digit scan unit and its bind to the top level.
`include "seven_segment_digit_scan_unit_defines.svh"

module sds_checker
   import sds_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic seen_ff;
   logic seen_in;
   logic [POS_W-1:0] last_index_ff;
   logic [POS_W-1:0] last_index_in;
   logic rsp_take;
   logic rsp_stall;
   logic units_shown;
   logic [POS_W-1:0] rsp_index;
   logic [POS_W-1:0] next_index;
   logic [DIGITS-1:0] rsp_enable;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_index = rsp_tdata[1:0];
   assign rsp_enable = rsp_tdata[5:2];
   assign next_index = last_index_ff + 2'd1;
   assign units_shown = rsp_tvalid && (rsp_index == POS_UNITS);

   always_comb begin
      seen_in = seen_ff || rsp_take;
      last_index_in = rsp_take ? rsp_index : last_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         last_index_ff <= '0;
      end else begin
         seen_ff <= seen_in;
         last_index_ff <= last_index_in;
      end
   end

   `SDS_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result not held")
   `SDS_ASSERT_NOW(a_enable, rsp_tvalid, rsp_enable == (4'b0001 << rsp_index), "enable mismatch")
   `SDS_ASSERT_NOW(a_index_advance, rsp_take && seen_ff, rsp_index == next_index, "index skipped")
   `SDS_ASSERT_NOW(a_units_point, units_shown, !rsp_tdata[13], "units point dark")

endmodule

bind seven_segment_digit_scan_unit sds_checker u_sds_checker (.*);

FILE: test/seven_segment_digit_scan_checker.sv
// Checker that predicts each scanned digit of the seven-segment unit and compares results.
module seven_segment_digit_scan_checker
   import sds_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // value_tenths[13:0], zeros [15:14]
   input  logic req_tuser,                   // decimal_all
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // digit_index[1:0], digit_enable[5:2],
                                             // segments_n[12:6], point_n[13], zeros
   output int mismatch_count,
   output int digits_pending
);

   // Active-high segment patterns of the digits 9 down to 0, digit 0 in the lowest bits.
   localparam logic [10*SEG_W-1:0] DIGIT_SEGMENTS = {
      7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   logic [POS_W-1:0] scan_position;
   rsp_fields_type scheduled_digits[$];

   function automatic rsp_fields_type scan_digit(input logic [POS_W-1:0] pos,
                                                 input logic [VALUE_W-1:0] tenths,
                                                 input logic all_points);
      rsp_fields_type digit;
      int unsigned place;
      int unsigned decimal;
      place = (pos == POS_HUNDREDS) ? 1000 : (pos == POS_TENS) ? 100 :
              (pos == POS_UNITS) ? 10 : 1;
      decimal = (32'(tenths) / place) % 10;
      digit.digit_index = pos;
      digit.digit_enable = DIGITS'(1) << pos;
      if ((pos == POS_HUNDREDS && tenths < HUNDREDS_BLANK_LIMIT) ||
          (pos == POS_TENS && tenths < TENS_BLANK_LIMIT)) begin
         digit.segments_n = SEG_BLANK_N;
      end else begin
         digit.segments_n = ~DIGIT_SEGMENTS[decimal*SEG_W +: SEG_W];
      end
      digit.point_n = !(pos == POS_UNITS || all_points);
      return digit;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int wanted);
      $display("ERROR at %0t: %s, got 0x%0h, expected 0x%0h", $time, what, got, wanted);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch_channels
      rsp_fields_type seen;
      rsp_fields_type wanted;
      if (reset) begin
         scan_position = '0;
         scheduled_digits.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            scan_position = scan_position + 1'b1;
            scheduled_digits.push_back(scan_digit(scan_position, req_tdata[VALUE_W-1:0],
                                                  req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_fields_type'(rsp_tdata[$bits(rsp_fields_type)-1:0]);
            if (scheduled_digits.size() == 0) begin
               report_mismatch("result transaction with no request pending", int'(seen), 0);
            end else begin
               wanted = scheduled_digits.pop_front();
               if (seen.digit_index != wanted.digit_index)
                  report_mismatch("digit_index", int'(seen.digit_index),
                                  int'(wanted.digit_index));
               if (seen.digit_enable != wanted.digit_enable)
                  report_mismatch("digit_enable", int'(seen.digit_enable),
                                  int'(wanted.digit_enable));
               if (seen.segments_n != wanted.segments_n)
                  report_mismatch("segments_n", int'(seen.segments_n),
                                  int'(wanted.segments_n));
               if (seen.point_n != wanted.point_n)
                  report_mismatch("point_n", int'(seen.point_n), int'(wanted.point_n));
            end
         end
      end
      digits_pending <= scheduled_digits.size();
   end

endmodule

FILE: test/tb_seven_segment_digit_scan_unit.sv
// Testbench top that drives refresh ticks into the digit scan unit and reports the verdict.
module tb_seven_segment_digit_scan_unit;
   import sds_pkg::*;

   localparam int DIRECTED_COUNT = 22;
   localparam int RANDOM_COUNT = 1350;
   localparam int DRAIN_AT = 400;
   localparam int HOLD_AT = 800;
   localparam int HOLD_CYCLES = 120;
   localparam int SETTLE_CYCLES = 10;
   localparam int IDLE_LIMIT = 2000;

   localparam logic [11*VALUE_W-1:0] DIRECTED_VALUES = {
      14'd8765, 14'd1234, 14'd16383, 14'd10000, 14'd9999, 14'd1000,
      14'd999, 14'd100, 14'd99, 14'd9, 14'd0
   };

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // value_tenths[13:0], zeros [15:14]
   logic req_tuser = 1'b0;                  // decimal_all
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // digit_index[1:0], digit_enable[5:2],
                                            // segments_n[12:6], point_n[13], zeros
   logic hold_request = 1'b0;
   int mismatch_count;
   int digits_pending;
   int idle_cycles = 0;

   seven_segment_digit_scan_unit dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   seven_segment_digit_scan_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .mismatch_count(mismatch_count),
      .digits_pending(digits_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic offer_reading(input logic [VALUE_W-1:0] tenths, input logic all_points);
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_W'(tenths);
      req_tuser <= all_points;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin : drive_readings
      int burst_left;
      int gap;
      logic [VALUE_W-1:0] tenths;
      logic all_points;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      burst_left = $urandom_range(1, 20);
      for (int i = 0; i < DIRECTED_COUNT + RANDOM_COUNT; i++) begin
         if (i < DIRECTED_COUNT) begin
            tenths = DIRECTED_VALUES[(i % 11)*VALUE_W +: VALUE_W];
            all_points = (i >= 11);
         end else begin
            case ($urandom_range(0, 4))
               0: tenths = VALUE_W'($urandom_range(0, 99));
               1: tenths = VALUE_W'($urandom_range(100, 999));
               2: tenths = VALUE_W'($urandom_range(1000, 9999));
               3: tenths = VALUE_W'($urandom_range(10000, 16383));
               default: tenths = VALUE_W'($urandom);
            endcase
            all_points = 1'($urandom_range(0, 1));
         end
         if (i == DRAIN_AT) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (digits_pending != 0);
         end
         if (i == HOLD_AT)
            hold_request <= 1'b1;
         offer_reading(tenths, all_points);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;
      do @(posedge clock); while (digits_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : drain_results
      int stall_mode;
      int stall_phase;
      bit held_off;
      stall_mode = 0;
      stall_phase = 0;
      held_off = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_request && !held_off) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (stall_phase % 32 == 0)
               stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= stall_phase[0];
               2: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            stall_phase++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
